// File: src/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the palette translucent blend
// Channel widths, distance bound, blend weight limits, the channel mix
// function and the tag that travels with a palette entry down the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

	localparam int CHAN_W   = 6;
	localparam int ENTRY_W  = 3 * CHAN_W;
	localparam int INDEX_W  = 8;
	localparam int WEIGHT_W = 4;
	localparam int MIX_W    = 4;
	localparam int DIST_W   = 15;

	localparam logic [DIST_W-1:0]   DIST_LIMIT  = DIST_W'(30000);
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(8);

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [DIST_W-1:0]  dist_t;

	// tag of one sweep beat: marks a live palette entry and its index
	typedef struct packed {
		logic   vld;
		index_t idx;
	} sweep_tag_t;

	// blend one channel: floor(s*w/32) + floor(d*(8-w)/32), weight 0..8
	function automatic logic [MIX_W-1:0] mix_chan(
		input chan_t               s,
		input chan_t               d,
		input logic [WEIGHT_W-1:0] w
	);
		logic [CHAN_W+WEIGHT_W-1:0] ps;
		logic [CHAN_W+WEIGHT_W-1:0] pd;
		logic [WEIGHT_W-1:0]        wd;
		wd = WEIGHT_FULL - w;
		ps = (CHAN_W+WEIGHT_W)'(s) * (CHAN_W+WEIGHT_W)'(w);
		pd = (CHAN_W+WEIGHT_W)'(d) * (CHAN_W+WEIGHT_W)'(wd);
		return MIX_W'(ps >> 5) + MIX_W'(pd >> 5);
	endfunction

endpackage

`default_nettype wire

// File: src/palette_translucent_blend.sv
// ----------------------------------------------------------------------------
// palette_translucent_blend: translucent blend with nearest palette search
// Loads a palette by write beats; a blend beat mixes two palette colors and
// sweeps the palette through one distance unit for the closest entry.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid / in_ready   action, entry_index, entry_red/green/blue,
//                                 overlay_index, dest_index, blend_weight
//  out      out_valid / out_ready color_index, rejected
//
//  A write beat gives no result.
//  A blend beat reads the dest, mixes it with the source while entry 0 is
//  read, sweeps one entry per cycle, drains through S_DRAIN1 and S_DRAIN2,
//  then outputs; the single RAM read port sets this order. A rejected blend goes straight to output.
//  Reset clears the entry valid bits at once; no clearing pass is needed.
//  in_ready is high only while idle; an untaken result stalls a blend's end.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_translucent_blend #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    action,
	input  wire ptb_pkg::index_t         entry_index,
	input  wire ptb_pkg::chan_t          entry_red,
	input  wire ptb_pkg::chan_t          entry_green,
	input  wire ptb_pkg::chan_t          entry_blue,
	input  wire ptb_pkg::index_t         overlay_index,
	input  wire ptb_pkg::index_t         dest_index,
	input  wire logic [ptb_pkg::WEIGHT_W-1:0] blend_weight,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output ptb_pkg::index_t              color_index,
	output logic                         rejected
);

	import ptb_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_DST,
		S_MIX,
		S_SWEEP,
		S_DRAIN1,
		S_DRAIN2,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         cnt_q;
	index_t                dst_q;
	logic [WEIGHT_W-1:0]   w_q;
	entry_t                src_q;
	chan_t                 tgt_r_q;
	chan_t                 tgt_g_q;
	chan_t                 tgt_b_q;
	dist_t                 best_q;
	index_t                best_idx_q;
	logic                  rej_q;
	logic                  out_valid_q;
	index_t                color_index_q;
	logic                  rejected_q;
	logic [PALETTE_ENTRIES-1:0] valid_q;
	logic                  rd_ok_s1;
	sweep_tag_t            tag_s1;

	logic                  accept;
	logic                  wr_en;
	index_t                rd_full;
	logic [AW-1:0]         rd_addr;
	logic                  rd_in_range;
	entry_t                rd_data;
	entry_t                rd_masked;
	dist_t                 dist_s2;
	sweep_tag_t            tag_s2;
	logic [MIX_W-1:0]      mix_r;
	logic [MIX_W-1:0]      mix_g;
	logic [MIX_W-1:0]      mix_b;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign wr_en       = accept && !action
		&& ({1'b0, entry_index} < (INDEX_W+1)'(PALETTE_ENTRIES));
	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;
	assign rejected    = rejected_q;

	// select the read address: source while idle, then dest, then the sweep
	always_comb begin
		case (state_q)
			S_IDLE:   rd_full = overlay_index;
			S_RD_DST: rd_full = dst_q;
			default:  rd_full = INDEX_W'(cnt_q);
		endcase
	end

	assign rd_addr     = rd_full[AW-1:0];
	assign rd_in_range = {1'b0, rd_full} < (INDEX_W+1)'(PALETTE_ENTRIES);

	// palette storage
	ptb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (entry_index[AW-1:0]),
		.wdata ({entry_red, entry_green, entry_blue}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// track written entries; hold the read qualifier and the sweep tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_ok_s1 <= 1'b0;
			tag_s1   <= '0;
		end else begin
			if (wr_en) begin
				valid_q[entry_index[AW-1:0]] <= 1'b1;
			end
			rd_ok_s1   <= rd_in_range && valid_q[rd_addr];
			tag_s1.vld <= (state_q == S_MIX) || (state_q == S_SWEEP);
			tag_s1.idx <= INDEX_W'(cnt_q);
		end
	end

	assign rd_masked = rd_ok_s1 ? rd_data : '0;

	// mix the source and dest colors per channel
	assign mix_r = mix_chan(src_q[3*CHAN_W-1:2*CHAN_W],
		rd_masked[3*CHAN_W-1:2*CHAN_W], w_q);
	assign mix_g = mix_chan(src_q[2*CHAN_W-1:CHAN_W],
		rd_masked[2*CHAN_W-1:CHAN_W], w_q);
	assign mix_b = mix_chan(src_q[CHAN_W-1:0], rd_masked[CHAN_W-1:0], w_q);

	// shared distance unit
	ptb_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tgt_r    (tgt_r_q),
		.tgt_g    (tgt_g_q),
		.tgt_b    (tgt_b_q),
		.entry    (rd_data),
		.entry_ok (rd_ok_s1),
		.tag_s1   (tag_s1),
		.dist_s2  (dist_s2),
		.tag_s2   (tag_s2)
	);

	// sequencer, best-match compare and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			dst_q         <= '0;
			w_q           <= '0;
			src_q         <= '0;
			tgt_r_q       <= '0;
			tgt_g_q       <= '0;
			tgt_b_q       <= '0;
			best_q        <= DIST_LIMIT;
			best_idx_q    <= '0;
			rej_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			color_index_q <= '0;
			rejected_q    <= 1'b0;
		end else begin
			// drop the result once taken
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// keep the first closest entry
			if (tag_s2.vld && (dist_s2 < best_q)) begin
				best_q     <= dist_s2;
				best_idx_q <= tag_s2.idx;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && action) begin
						best_q     <= DIST_LIMIT;
						best_idx_q <= '0;
						cnt_q      <= '0;
						dst_q      <= dest_index;
						w_q        <= blend_weight;
						if (blend_weight > WEIGHT_FULL) begin
							rej_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							rej_q   <= 1'b0;
							state_q <= S_RD_DST;
						end
					end
				end
				S_RD_DST: begin
					src_q   <= rd_masked;
					state_q <= S_MIX;
				end
				S_MIX: begin
					tgt_r_q <= {mix_r, 2'b10};
					tgt_g_q <= {mix_g, 2'b10};
					tgt_b_q <= {mix_b, 2'b10};
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						state_q <= S_DRAIN1;
					end
				end
				S_DRAIN1: begin
					state_q <= S_DRAIN2;
				end
				S_DRAIN2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						color_index_q <= rej_q ? '0 : best_idx_q;
						rejected_q    <= rej_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/ptb_dist.sv
// ----------------------------------------------------------------------------
// ptb_dist: shared squared-distance unit
// Takes one palette entry per cycle and registers its squared RGB distance
// to the blend target, together with the entry's sweep tag.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_dist (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ptb_pkg::chan_t      tgt_r,
	input  wire ptb_pkg::chan_t      tgt_g,
	input  wire ptb_pkg::chan_t      tgt_b,
	input  wire ptb_pkg::entry_t     entry,
	input  wire logic                entry_ok,
	input  wire ptb_pkg::sweep_tag_t tag_s1,
	output ptb_pkg::dist_t           dist_s2,
	output ptb_pkg::sweep_tag_t      tag_s2
);

	import ptb_pkg::*;

	entry_t                  ent;
	chan_t                   dr;
	chan_t                   dg;
	chan_t                   db;
	logic [2*CHAN_W-1:0]     sqr;
	logic [2*CHAN_W-1:0]     sqg;
	logic [2*CHAN_W-1:0]     sqb;
	dist_t                   dist_sum;

	// unwritten or out-of-range entries read as black
	assign ent = entry_ok ? entry : '0;

	// absolute channel differences
	always_comb begin
		chan_t er;
		chan_t eg;
		chan_t eb;
		er = ent[3*CHAN_W-1:2*CHAN_W];
		eg = ent[2*CHAN_W-1:CHAN_W];
		eb = ent[CHAN_W-1:0];
		dr = (tgt_r >= er) ? tgt_r - er : er - tgt_r;
		dg = (tgt_g >= eg) ? tgt_g - eg : eg - tgt_g;
		db = (tgt_b >= eb) ? tgt_b - eb : eb - tgt_b;
	end

	// squares and their sum
	assign sqr      = (2*CHAN_W)'(dr) * (2*CHAN_W)'(dr);
	assign sqg      = (2*CHAN_W)'(dg) * (2*CHAN_W)'(dg);
	assign sqb      = (2*CHAN_W)'(db) * (2*CHAN_W)'(db);
	assign dist_sum = DIST_W'(sqr) + DIST_W'(sqg) + DIST_W'(sqb);

	// hold the distance for the compare stage
	always_ff @(posedge clk) begin
		dist_s2 <= dist_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

endmodule

`default_nettype wire
